FILE: hw/rtl/camera_pitch_orbit_unit_macros.svh
// Assertion shorthands for the checker file.
`ifndef CAMERA_PITCH_ORBIT_UNIT_MACROS_SVH
`define CAMERA_PITCH_ORBIT_UNIT_MACROS_SVH

// Checked only while out of reset.
`define CPO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CPO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/cpo_pkg.sv
package cpo_pkg;

  // datapath width of all CORDIC rows (covers gain growth of three chains)
  localparam int CW = 38;
  // angle residue width in the rotation row
  localparam int ZW = 34;
  localparam int ADDR_W = 3;

  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam logic [31:0] HALF    = 32'h8000_0000;
  localparam logic [13:0] MARGIN_RST = 14'd128;
  localparam logic [15:0] TURN_UNITS = 16'd46080;
  // floor(a/45) = (a * DIV45_MUL) >> DIV45_SH, exact for a <= 32768
  localparam logic [15:0] DIV45_MUL = 16'd46604;
  localparam int DIV45_SH = 21;

  // register index, taken from paddr[2]
  localparam logic IDX_POLE_MARGIN = 1'b0;

  typedef enum logic [1:0] {
    ST_MOVED = 2'd0,
    ST_POLE  = 2'd1,
    ST_FLAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] step_angle;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    status_e            status;
  } out_beat_t;

  // per-item context that rides along the cell rows
  typedef struct packed {
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [32:0] dy;
    logic [31:0]        ang;
    logic               flip;
    logic               hzero;
  } ctx_t;

  typedef struct packed {
    logic              valid;
    ctx_t              ctx;
    logic signed [CW-1:0] hx;
    logic signed [CW-1:0] hz;
    logic [31:0]       dirs;
  } hv_beat_t;

  typedef struct packed {
    logic              valid;
    ctx_t              ctx;
    logic [31:0]       dirs;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic [31:0]       acc;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic signed [ZW-1:0] rz;
  } pt_beat_t;

  typedef struct packed {
    logic              valid;
    ctx_t              ctx;
    logic [31:0]       dirs;
    logic signed [CW-1:0] hx;
    logic signed [CW-1:0] hz;
    logic signed [CW-1:0] x;
    logic [31:0]       phi;
  } rp_beat_t;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef logic [21:0] frac_tab_t [45];

  // floor((v * 2^22 + 22) / 45): fractional part of the step conversion
  function automatic frac_tab_t step_frac_tab();
    frac_tab_t t;
    for (int v = 0; v < 45; v++) begin
      t[v] = 22'(((64'(v) << 22) + 64'd22) / 64'd45);
    end
    return t;
  endfunction

  localparam frac_tab_t STEP_FRAC = step_frac_tab();

  // Q30 product of the squared CORDIC stage gains (1 + 2^-2i)
  function automatic logic [63:0] gain_p(int n);
    logic [63:0] p;
    p = 64'd1 << 30;
    for (int i = 0; i < n; i++) begin
      p = p + (p >> (2 * i));
    end
    return p;
  endfunction

  // round(2^60 / p), bitwise long division
  function automatic logic [63:0] recip_round(logic [63:0] p);
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    num = (64'd1 << 60) + (p >> 1);
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= p) begin
        rem = rem - p;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res = '0;
    rem = v;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bitv > rem) bitv = bitv >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bitv != 64'd0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/camera_pitch_orbit_unit.sv
// Throughput: one beat per cycle; the whole pipeline holds only while a
// result beat sits stalled in the output register.
// Rows: horizontal vectoring, pitch vectoring+rotation, direction replay.
// Reset: all valid bits clear, pole_margin returns to 128 (one degree).
module camera_pitch_orbit_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  cpo_pkg::in_beat_t           in_beat_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output cpo_pkg::out_beat_t          out_beat_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpo_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cpo_pkg::*;

  // CORDIC gain constants, all Q30, fixed at elaboration
  localparam logic [63:0] GAIN_P = gain_p(CORDIC_STAGES);
  localparam logic [63:0] IK2_64 = recip_round(GAIN_P);
  localparam logic [63:0] IK_64  = isqrt64(IK2_64 << 30);
  localparam logic [29:0] IK  = IK_64[29:0];
  localparam logic [29:0] IK2 = IK2_64[29:0];

  // ------------------------------------------------------------------
  // Configuration port: single register, writes to other indexes dropped
  // ------------------------------------------------------------------
  logic [13:0] margin_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == IDX_POLE_MARGIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RST;
    end else if (cfg_wr) begin
      margin_q <= pwdata[13:0];
    end
  end

  assign prdata = (paddr[2] == IDX_POLE_MARGIN) ? {18'd0, margin_q} : 32'd0;

  // ------------------------------------------------------------------
  // Flow control: every stage moves together unless the output beat is
  // held by the consumer.
  // ------------------------------------------------------------------
  logic out_valid_q;
  logic en;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ------------------------------------------------------------------
  // Front stage 1: offset, |step| and the reciprocal product for /45
  // ------------------------------------------------------------------
  typedef struct packed {
    logic              valid;
    ctx_t              ctx;
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic [16:0]       amag;
    logic [32:0]       prod;
    logic              neg;
  } f1_t;

  f1_t f1_d, f1_q;

  always_comb begin
    f1_d = '0;
    f1_d.valid = in_valid_i;
    f1_d.ctx.pivot_x = in_beat_i.pivot_x;
    f1_d.ctx.pivot_y = in_beat_i.pivot_y;
    f1_d.ctx.pivot_z = in_beat_i.pivot_z;
    f1_d.ctx.point_x = in_beat_i.point_x;
    f1_d.ctx.point_y = in_beat_i.point_y;
    f1_d.ctx.point_z = in_beat_i.point_z;
    f1_d.dx = 33'(in_beat_i.point_x) - 33'(in_beat_i.pivot_x);
    f1_d.ctx.dy = 33'(in_beat_i.point_y) - 33'(in_beat_i.pivot_y);
    f1_d.dz = 33'(in_beat_i.point_z) - 33'(in_beat_i.pivot_z);
    f1_d.neg = in_beat_i.step_angle[15];
    f1_d.amag = in_beat_i.step_angle[15] ? 17'(-17'(in_beat_i.step_angle))
                                         : 17'(in_beat_i.step_angle);
    f1_d.prod = 33'(f1_d.amag) * 33'(DIV45_MUL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= '0;
    end else if (en) begin
      f1_q <= f1_d;
    end
  end

  // ------------------------------------------------------------------
  // Front stage 2: step to binary angle (a = 45u + v, table for v),
  // half-turn flip of the horizontal offset
  // ------------------------------------------------------------------
  logic [10:0] step_u;
  logic [16:0] step_v;
  logic [32:0] step_q;
  hv_beat_t    f2_d;
  hv_beat_t    hv_chain [CORDIC_STAGES+1];

  always_comb begin
    step_u = f1_q.prod[DIV45_SH+10:DIV45_SH];
    step_v = f1_q.amag - 17'((17'(step_u) << 5) + (17'(step_u) << 3)
                             + (17'(step_u) << 2) + 17'(step_u));
    step_q = (33'(step_u) << 22) + 33'(STEP_FRAC[step_v[5:0]]);
    f2_d = '0;
    f2_d.valid = f1_q.valid;
    f2_d.ctx = f1_q.ctx;
    f2_d.ctx.ang = f1_q.neg ? 32'(-step_q[31:0]) : step_q[31:0];
    f2_d.ctx.flip = f1_q.dx[32];
    f2_d.ctx.hzero = (f1_q.dx == '0) && (f1_q.dz == '0);
    f2_d.hx = f1_q.dx[32] ? -CW'(f1_q.dx) : CW'(f1_q.dx);
    f2_d.hz = f1_q.dx[32] ? -CW'(f1_q.dz) : CW'(f1_q.dz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_chain[0] <= '0;
    end else if (en) begin
      hv_chain[0] <= f2_d;
    end
  end

  // ------------------------------------------------------------------
  // Row 1: horizontal vectoring, yields K*H and the direction word
  // ------------------------------------------------------------------
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_hvec
    cpo_hvec_cell #(.STAGE(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .beat_i (hv_chain[g]),
      .beat_o (hv_chain[g+1])
    );
  end

  // remove the gain from K*H; context waits in hs1_q and hs2_q alongside
  logic signed [CW-1:0] h_scaled;
  hv_beat_t hs1_q, hs2_q;

  cpo_scale u_scale_h (
    .clk_i   (clk_i),
    .en_i    (en),
    .value_i (hv_chain[CORDIC_STAGES].hx),
    .gain_i  (IK),
    .value_o (h_scaled)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs1_q <= '0;
      hs2_q <= '0;
    end else if (en) begin
      hs1_q <= hv_chain[CORDIC_STAGES];
      hs2_q <= hs1_q;
    end
  end

  // ------------------------------------------------------------------
  // Row 2 entry: quarter-turn prerotation for the polar angle, half-turn
  // prerotation for a step beyond a quarter turn
  // ------------------------------------------------------------------
  pt_beat_t pt_chain [CORDIC_STAGES+1];
  logic signed [CW-1:0] dyw;
  logic signed [ZW-1:0] z0;

  always_comb begin
    dyw = CW'(hs2_q.ctx.dy);
    z0 = ZW'($signed(hs2_q.ctx.ang));
    pt_chain[0] = '0;
    pt_chain[0].valid = hs2_q.valid;
    pt_chain[0].ctx = hs2_q.ctx;
    pt_chain[0].dirs = hs2_q.dirs;
    if (dyw[CW-1]) begin
      pt_chain[0].vx = h_scaled;
      pt_chain[0].vy = -dyw;
      pt_chain[0].acc = QUARTER;
    end else begin
      pt_chain[0].vx = dyw;
      pt_chain[0].vy = h_scaled;
      pt_chain[0].acc = 32'd0;
    end
    if (z0 > $signed(ZW'(QUARTER))) begin
      pt_chain[0].rx = -dyw;
      pt_chain[0].ry = -h_scaled;
      pt_chain[0].rz = z0 - $signed(ZW'(HALF));
    end else if (z0 < -$signed(ZW'(QUARTER))) begin
      pt_chain[0].rx = -dyw;
      pt_chain[0].ry = -h_scaled;
      pt_chain[0].rz = z0 + $signed(ZW'(HALF));
    end else begin
      pt_chain[0].rx = dyw;
      pt_chain[0].ry = h_scaled;
      pt_chain[0].rz = z0;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_pitch
    cpo_pitch_cell #(.STAGE(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .beat_i (pt_chain[g]),
      .beat_o (pt_chain[g+1])
    );
  end

  // ------------------------------------------------------------------
  // Row 3: rotate (K*H', 0) back through the recorded directions
  // ------------------------------------------------------------------
  rp_beat_t rp_chain [CORDIC_STAGES+1];

  always_comb begin
    rp_chain[0] = '0;
    rp_chain[0].valid = pt_chain[CORDIC_STAGES].valid;
    rp_chain[0].ctx = pt_chain[CORDIC_STAGES].ctx;
    rp_chain[0].dirs = pt_chain[CORDIC_STAGES].dirs;
    rp_chain[0].hx = pt_chain[CORDIC_STAGES].ry;
    rp_chain[0].hz = '0;
    rp_chain[0].x = pt_chain[CORDIC_STAGES].rx;
    rp_chain[0].phi = pt_chain[CORDIC_STAGES].acc + pt_chain[CORDIC_STAGES].ctx.ang;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_replay
    cpo_replay_cell #(.STAGE(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .beat_i (rp_chain[g]),
      .beat_o (rp_chain[g+1])
    );
  end

  // ------------------------------------------------------------------
  // Tail: undo the half turn, gain correction, pole test
  // ------------------------------------------------------------------
  rp_beat_t rp_last;
  logic signed [CW-1:0] tx_in, tz_in;
  logic signed [CW-1:0] sx, sy, sz;

  assign rp_last = rp_chain[CORDIC_STAGES];
  assign tx_in = rp_last.ctx.flip ? -rp_last.hx : rp_last.hx;
  assign tz_in = rp_last.ctx.flip ? -rp_last.hz : rp_last.hz;

  cpo_scale u_scale_x (
    .clk_i (clk_i), .en_i (en), .value_i (tx_in), .gain_i (IK2), .value_o (sx)
  );
  cpo_scale u_scale_z (
    .clk_i (clk_i), .en_i (en), .value_i (tz_in), .gain_i (IK2), .value_o (sz)
  );
  cpo_scale u_scale_y (
    .clk_i (clk_i), .en_i (en), .value_i (rp_last.x), .gain_i (IK), .value_o (sy)
  );

  // distance of the new polar angle from the nearest pole
  logic [30:0] phi_r, pole_dist;
  logic [46:0] dist_prod_q;
  logic        refuse_q;
  logic        t1_valid_q, t2_valid_q;
  ctx_t        t1_ctx_q, t2_ctx_q;

  assign phi_r = rp_last.phi[30:0];
  assign pole_dist = (phi_r <= 31'(QUARTER)) ? phi_r : 31'(32'(HALF) - 32'(phi_r));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
    end else if (en) begin
      t1_valid_q <= rp_last.valid;
      t2_valid_q <= t1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_ctx_q    <= rp_last.ctx;
      dist_prod_q <= 47'(pole_dist) * 47'(TURN_UNITS);
      t2_ctx_q    <= t1_ctx_q;
      refuse_q    <= dist_prod_q < (47'(margin_q) << 32);
    end
  end

  function automatic logic signed [31:0] sat32(logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -40'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  out_beat_t out_d, out_q;

  always_comb begin
    out_d.new_x = t2_ctx_q.point_x;
    out_d.new_y = t2_ctx_q.point_y;
    out_d.new_z = t2_ctx_q.point_z;
    if (t2_ctx_q.hzero) begin
      out_d.status = ST_FLAT;
    end else if (refuse_q) begin
      out_d.status = ST_POLE;
    end else begin
      out_d.status = ST_MOVED;
      out_d.new_x = sat32(40'(t2_ctx_q.pivot_x) + 40'(sx));
      out_d.new_y = sat32(40'(t2_ctx_q.pivot_y) + 40'(sy));
      out_d.new_z = sat32(40'(t2_ctx_q.pivot_z) + 40'(sz));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= t2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

FILE: hw/rtl/cpo_hvec_cell.sv
// One vectoring step on the horizontal offset; records its direction.
module cpo_hvec_cell #(
  parameter int STAGE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cpo_pkg::hv_beat_t  beat_i,
  output cpo_pkg::hv_beat_t  beat_o
);
  import cpo_pkg::*;

  hv_beat_t beat_d, beat_q;
  logic signed [CW-1:0] hx, hz;

  always_comb begin
    beat_d = beat_i;
    hx = beat_i.hx;
    hz = beat_i.hz;
    if (!hz[CW-1]) begin
      beat_d.hx = hx + (hz >>> STAGE);
      beat_d.hz = hz - (hx >>> STAGE);
      beat_d.dirs[STAGE] = 1'b1;
    end else begin
      beat_d.hx = hx - (hz >>> STAGE);
      beat_d.hz = hz + (hx >>> STAGE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

FILE: hw/rtl/cpo_pitch_cell.sv
// One step of the polar-angle vectoring and one of the step rotation.
module cpo_pitch_cell #(
  parameter int STAGE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cpo_pkg::pt_beat_t  beat_i,
  output cpo_pkg::pt_beat_t  beat_o
);
  import cpo_pkg::*;

  pt_beat_t beat_d, beat_q;
  logic signed [CW-1:0] vx, vy, rx, ry;
  logic signed [ZW-1:0] rz, atan_z;

  always_comb begin
    beat_d = beat_i;
    vx = beat_i.vx;
    vy = beat_i.vy;
    rx = beat_i.rx;
    ry = beat_i.ry;
    rz = beat_i.rz;
    atan_z = $signed(ZW'(ATAN_TAB[STAGE]));
    if (!vy[CW-1]) begin
      beat_d.vx = vx + (vy >>> STAGE);
      beat_d.vy = vy - (vx >>> STAGE);
      beat_d.acc = beat_i.acc + ATAN_TAB[STAGE];
    end else begin
      beat_d.vx = vx - (vy >>> STAGE);
      beat_d.vy = vy + (vx >>> STAGE);
      beat_d.acc = beat_i.acc - ATAN_TAB[STAGE];
    end
    if (!rz[ZW-1]) begin
      beat_d.rx = rx - (ry >>> STAGE);
      beat_d.ry = ry + (rx >>> STAGE);
      beat_d.rz = rz - atan_z;
    end else begin
      beat_d.rx = rx + (ry >>> STAGE);
      beat_d.ry = ry - (rx >>> STAGE);
      beat_d.rz = rz + atan_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

FILE: hw/rtl/cpo_replay_cell.sv
// Replays one recorded horizontal direction, inverse sense.
module cpo_replay_cell #(
  parameter int STAGE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cpo_pkg::rp_beat_t  beat_i,
  output cpo_pkg::rp_beat_t  beat_o
);
  import cpo_pkg::*;

  rp_beat_t beat_d, beat_q;
  logic signed [CW-1:0] hx, hz;

  always_comb begin
    beat_d = beat_i;
    hx = beat_i.hx;
    hz = beat_i.hz;
    if (beat_i.dirs[STAGE]) begin
      beat_d.hx = hx - (hz >>> STAGE);
      beat_d.hz = hz + (hx >>> STAGE);
    end else begin
      beat_d.hx = hx + (hz >>> STAGE);
      beat_d.hz = hz - (hx >>> STAGE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

FILE: hw/rtl/cpo_scale.sv
// Sign-magnitude multiply by a Q30 gain, rounded half away from zero.
// Two stages: split partial products, then sum and round.
module cpo_scale (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [cpo_pkg::CW-1:0] value_i,
  input  logic [29:0]                gain_i,
  output logic signed [cpo_pkg::CW-1:0] value_o
);
  import cpo_pkg::*;

  localparam int LW = CW / 2;
  localparam int HW = CW - LW;
  localparam int SW = CW + 30;

  logic [CW-1:0]    mag;
  logic [LW+29:0]   pl_q;
  logic [HW+29:0]   ph_q;
  logic             neg_q;
  logic [SW-1:0]    sum;
  logic [CW-1:0]    rmag;
  logic signed [CW-1:0] res_q;

  assign mag = value_i[CW-1] ? CW'(-value_i) : CW'(value_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= value_i[CW-1];
      pl_q  <= (LW+30)'(mag[LW-1:0]) * (LW+30)'(gain_i);
      ph_q  <= (HW+30)'(mag[CW-1:LW]) * (HW+30)'(gain_i);
    end
  end

  assign sum  = (SW'(ph_q) << LW) + SW'(pl_q) + (SW'(1) << 29);
  assign rmag = sum[SW-1:30];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= neg_q ? -$signed(rmag) : $signed(rmag);
    end
  end

  assign value_o = res_q;

endmodule

FILE: hw/rtl/cpo_checker.sv
`include "camera_pitch_orbit_unit_macros.svh"

module cpo_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input cpo_pkg::in_beat_t           in_beat_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input cpo_pkg::out_beat_t          out_beat_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [cpo_pkg::ADDR_W-1:0]  paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);
  import cpo_pkg::*;

  // input only backs up behind a held result beat
  `CPO_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stall without held output")
  // held result beat keeps its payload
  `CPO_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_beat_o)), "held beat changed")
  // a result beat leaves only when taken
  `CPO_ASSERT(a_out_drop, $fell(out_valid_o) |-> $past(!out_stall_i), "result beat lost")
  // register reads back what was written
  `CPO_ASSERT(a_cfg_rb, (psel && penable && pwrite && (paddr[2] == IDX_POLE_MARGIN)) |=> ((paddr[2] != IDX_POLE_MARGIN) || (prdata[13:0] == $past(pwdata[13:0]))), "pole margin readback mismatch")
  `CPO_ASSERT_ALWAYS(a_pready, pready == 1'b1, "pready low")

endmodule

bind camera_pitch_orbit_unit cpo_checker u_cpo_checker (.*);
